FILE: rtl/core/shell_command_lexer_assert.svh
// assertion macros for the shell command lexer
`ifndef SHELL_COMMAND_LEXER_ASSERT_SVH
`define SHELL_COMMAND_LEXER_ASSERT_SVH

`ifndef SYNTHESIS

// implication checked in the same cycle
`define SHCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shell_command_lexer assertion failed");

// implication checked in the cycle after the antecedent
`define SHCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shell_command_lexer assertion failed");

`else

`define SHCL_ASSERT_IMP(lbl, ante, cons)
`define SHCL_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/core/shcl_pkg.sv
// types, codes and character classes for the shell command lexer
package shcl_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;
  localparam int ERR_W  = 2;

  localparam logic [KIND_W-1:0] KIND_NAME  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REDIR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PIPE  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNCLOSED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_OPT  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_NAME = 2'd3;

  localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7c;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3c;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3e;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5f;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_NAME = 6'b000010,
    MODE_OPT  = 6'b000100,
    MODE_STR  = 6'b001000,
    MODE_GT   = 6'b010000,
    MODE_SKIP = 6'b100000
  } mode_t;

  typedef struct packed {
    logic              in_token;
    logic [KIND_W-1:0] kind;
    logic              tok_start;
    logic              tok_end;
    logic              prior_closed;
    logic [ERR_W-1:0]  err;
  } shcl_res_t;

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]};
  endfunction

  function automatic logic is_name_char(input logic [CHAR_W-1:0] c);
    return (c == CH_DOT) || (c == CH_UNDER) || is_alnum(c);
  endfunction

endpackage

FILE: rtl/core/shcl_step.sv
// per-word lexing logic: result flags and next mode from mode, byte and line-last flag
module shcl_step
  import shcl_pkg::*;
(
  input  mode_t              mode,
  input  logic [CHAR_W-1:0]  char_in,
  input  logic               line_last,
  output shcl_res_t          res,
  output mode_t              mode_nxt
);

  typedef struct packed {
    shcl_res_t res;
    mode_t     mode;
  } step_t;

  function automatic shcl_res_t mark_tok(input logic [KIND_W-1:0] kind,
                                         input logic st, input logic en);
    shcl_res_t r;
    r              = '0;
    r.in_token     = 1'b1;
    r.kind         = kind;
    r.tok_start    = st;
    r.tok_end      = en;
    return r;
  endfunction

  function automatic step_t fail_tok(input logic [ERR_W-1:0] code);
    step_t s;
    s.res     = '0;
    s.res.err = code;
    s.mode    = MODE_SKIP;
    return s;
  endfunction

  function automatic step_t from_idle(input logic [CHAR_W-1:0] c, input logic last);
    step_t s;
    s.res  = '0;
    s.mode = MODE_IDLE;
    if (is_sep(c)) begin
      s.mode = MODE_IDLE;
    end else if (c == CH_PIPE) begin
      s.res = mark_tok(KIND_PIPE, 1'b1, 1'b1);
    end else if (c == CH_LT) begin
      s.res = mark_tok(KIND_REDIR, 1'b1, 1'b1);
    end else if (c == CH_GT) begin
      s.res  = mark_tok(KIND_REDIR, 1'b1, last);
      s.mode = last ? MODE_IDLE : MODE_GT;
    end else if (c == CH_QUOTE) begin
      if (last) begin
        s = fail_tok(ERR_UNCLOSED);
      end else begin
        s.res  = mark_tok(KIND_STR, 1'b1, 1'b0);
        s.mode = MODE_STR;
      end
    end else if (c == CH_DASH) begin
      s.res  = mark_tok(KIND_OPT, 1'b1, last);
      s.mode = MODE_OPT;
    end else if (is_name_char(c)) begin
      s.res  = mark_tok(KIND_NAME, 1'b1, last);
      s.mode = MODE_NAME;
    end else begin
      s = fail_tok(ERR_BAD_NAME);
    end
    return s;
  endfunction

  step_t s;

  always_comb begin
    s.res  = '0;
    s.mode = mode;
    case (mode)
      MODE_NAME: begin
        if (is_sep(char_in)) begin
          s.res.prior_closed = 1'b1;
          s.mode             = MODE_IDLE;
        end else if (is_name_char(char_in)) begin
          s.res = mark_tok(KIND_NAME, 1'b0, line_last);
        end else begin
          s = fail_tok(ERR_BAD_NAME);
        end
      end
      MODE_OPT: begin
        if (is_sep(char_in)) begin
          s.res.prior_closed = 1'b1;
          s.mode             = MODE_IDLE;
        end else if (is_alnum(char_in)) begin
          s.res = mark_tok(KIND_OPT, 1'b0, line_last);
        end else begin
          s = fail_tok(ERR_BAD_OPT);
        end
      end
      MODE_STR: begin
        if (char_in == CH_QUOTE) begin
          s.res  = mark_tok(KIND_STR, 1'b0, 1'b1);
          s.mode = MODE_IDLE;
        end else if (line_last) begin
          s = fail_tok(ERR_UNCLOSED);
        end else begin
          s.res = mark_tok(KIND_STR, 1'b0, 1'b0);
        end
      end
      MODE_GT: begin
        if (char_in == CH_GT) begin
          s.res  = mark_tok(KIND_REDIR, 1'b0, 1'b1);
          s.mode = MODE_IDLE;
        end else begin
          // pending '>' closes; the close flag survives an error on this byte
          s                  = from_idle(char_in, line_last);
          s.res.prior_closed = 1'b1;
        end
      end
      MODE_SKIP: begin
        s.res = '0;
      end
      default: begin
        s = from_idle(char_in, line_last);
      end
    endcase
    if (line_last) begin
      s.mode = MODE_IDLE;
    end
  end

  assign res      = s.res;
  assign mode_nxt = s.mode;

endmodule

FILE: rtl/core/shell_command_lexer.sv
// Shell command lexer top level: input register, lexing step and result register.
//
// Input channel: one byte of a command line per word on in_char_in, with
// in_line_last high on the line's final byte. A word is taken at a rising
// edge with in_valid high and in_stall low.
// Result channel: one result word per input word, in order, on the out_
// ports; taken at a rising edge with out_valid high and out_stall low.
// A word passes from the input register into the result register.
// Throughput: one word per cycle while out_stall is low; the lexing
// mode register is updated in the same cycle that a byte moves from
// the input register into the result register.
// When the receiver stalls, the result register holds, and the input
// register still takes one more word; in_stall rises only when both are
// full.
// Reset (rst_n low, synchronous) empties both registers and returns the
// lexer to idle between tokens.
`include "shell_command_lexer_assert.svh"

module shell_command_lexer
  import shcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic              in_line_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_in_token,
  output logic [KIND_W-1:0] out_token_kind,
  output logic              out_token_start,
  output logic              out_token_end,
  output logic              out_prior_closed,
  output logic [ERR_W-1:0]  out_error_code,
  output logic              out_line_done
);

  logic              s1_valid_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_last_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  shcl_res_t         out_res_r;
  mode_t             mode_r;
  mode_t             mode_nxt;
  shcl_res_t         step_res;
  logic              in_take;
  logic              s1_move;
  logic              err_shown;
  logic              tok_flags;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  shcl_step u_step (
    .mode      (mode_r),
    .char_in   (s1_char_r),
    .line_last (s1_last_r),
    .res       (step_res),
    .mode_nxt  (mode_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_IDLE;
    end else begin
      s1_valid_r  <= in_take || (s1_valid_r && !s1_move);
      out_valid_r <= s1_move || (out_valid_r && out_stall);
      if (s1_move) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_line_last;
    end
    if (s1_move) begin
      out_char_r <= s1_char_r;
      out_last_r <= s1_last_r;
      out_res_r  <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_char_out     = out_char_r;
  assign out_in_token     = out_res_r.in_token;
  assign out_token_kind   = out_res_r.kind;
  assign out_token_start  = out_res_r.tok_start;
  assign out_token_end    = out_res_r.tok_end;
  assign out_prior_closed = out_res_r.prior_closed;
  assign out_error_code   = out_res_r.err;
  assign out_line_done    = out_last_r;

  assign err_shown = out_valid_r && (out_res_r.err != ERR_NONE);
  assign tok_flags = out_res_r.in_token || out_res_r.tok_start || out_res_r.tok_end;

  `SHCL_ASSERT_IMP(a_err_no_token, err_shown, !tok_flags)
  `SHCL_ASSERT_IMP(a_start_in_token, out_valid_r && out_token_start, out_in_token)
  `SHCL_ASSERT_IMP(a_kind_zero_outside, out_valid_r && !out_in_token, out_token_kind == KIND_NAME)
  `SHCL_ASSERT_NXT(a_idle_after_line, s1_move && s1_last_r, mode_r == MODE_IDLE)

endmodule
